// ===== sv/bis_pkg.sv =====
// Shared types and constants for the bounded integer set core.
// No dependencies; imported by every module of the block.
package bis_pkg;

	localparam int ValueW = 32;
	localparam int CountOutW = 6;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic found;
		status_t status;
		logic [CountOutW-1:0] count;
	} res_t;

endpackage

// ===== sv/bounded_integer_set_core.sv =====
// Bounded integer set core: top level with entry store, sequencer and result register.
// A result beat is offered once the scan and decision for its input beat are done. The worst
// case is a remove that shifts later entries down; a query or insert does no shift.
// One item is in work at a time: no new input beat is taken until its result is handed on.
// The result register lets a new beat enter while the last result waits to be taken.
// Reset clears the count, so the set starts empty; entries are not cleared.
module bounded_integer_set_core #(
	parameter int CAPACITY = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic signed [31:0] value,
	output logic out_valid,
	input logic out_ready,
	output logic found,
	output logic [1:0] status,
	output logic [5:0] count
);
	import bis_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	res_t res;
	res_t out_q;
	logic res_valid;
	logic res_ready;
	logic out_valid_q;
	logic mem_re;
	logic mem_we;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	logic [ValueW-1:0] mem_wdata;
	logic [ValueW-1:0] mem_rdata;

	bis_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.re(mem_re),
		.raddr(mem_raddr),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	bis_seq #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.value(value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found = out_q.found;
	assign status = out_q.status;
	assign count = out_q.count;

endmodule

// ===== sv/bis_mem.sv =====
// Entry store of the set: one write port and one registered read port.
// Depends on bis_pkg for the entry width.
module bis_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input logic clk,
	input logic re,
	input logic [AW-1:0] raddr,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [bis_pkg::ValueW-1:0] wdata,
	output logic [bis_pkg::ValueW-1:0] rdata
);
	import bis_pkg::*;

	logic [ValueW-1:0] mem_q [DEPTH];
	logic [ValueW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bis_seq.sv =====
// Sequencer of the set: scans entries through one comparator, then inserts,
// or shifts later entries down on removal. Depends on bis_pkg.
module bis_seq #(
	parameter int CAPACITY = 32,
	parameter int AW = 5,
	parameter int CW = 6
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] func,
	input logic signed [bis_pkg::ValueW-1:0] value,
	output logic res_valid,
	input logic res_ready,
	output bis_pkg::res_t res,
	output logic mem_re,
	output logic [AW-1:0] mem_raddr,
	output logic mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [bis_pkg::ValueW-1:0] mem_wdata,
	input logic [bis_pkg::ValueW-1:0] mem_rdata
);
	import bis_pkg::*;

	state_t state_q, state_d;
	logic [1:0] func_q, func_d;
	logic [ValueW-1:0] value_q, value_d;
	logic found_q, found_d;
	status_t status_q, status_d;
	logic [AW-1:0] slot_q, slot_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] cmp_idx_q, cmp_idx_d;
	logic cmp_v_q, cmp_v_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] last_idx;
	logic hit;
	logic at_last;

	assign last_idx = count_q - CW'(1);
	assign hit = cmp_v_q && (mem_rdata == value_q);
	assign at_last = cmp_v_q && (cmp_idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			cmp_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cmp_v_q <= cmp_v_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		value_q <= value_d;
		found_q <= found_d;
		status_q <= status_d;
		slot_q <= slot_d;
		idx_q <= idx_d;
		cmp_idx_q <= cmp_idx_d;
	end

	always_comb begin
		state_d = state_q;
		func_d = func_q;
		value_d = value_q;
		found_d = found_q;
		status_d = status_q;
		slot_d = slot_q;
		idx_d = idx_q;
		cmp_idx_d = cmp_idx_q;
		cmp_v_d = 1'b0;
		count_d = count_q;
		in_ready = 1'b0;
		res_valid = 1'b0;
		mem_re = 1'b0;
		mem_raddr = idx_q[AW-1:0];
		mem_we = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = value_q;

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					func_d = func;
					value_d = value;
					found_d = 1'b0;
					idx_d = '0;
					state_d = (count_q == '0) ? S_DECIDE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					found_d = 1'b1;
					slot_d = cmp_idx_q[AW-1:0];
					state_d = S_DECIDE;
				end else if (at_last) begin
					state_d = S_DECIDE;
				end else if (idx_q < count_q) begin
					mem_re = 1'b1;
					idx_d = idx_q + CW'(1);
					cmp_idx_d = idx_q;
					cmp_v_d = 1'b1;
				end
			end
			S_DECIDE: begin
				state_d = S_RESULT;
				case (func_q)
					OP_INSERT: begin
						if (found_q) begin
							status_d = ST_DUPLICATE;
						end else if (count_q == CW'(CAPACITY)) begin
							status_d = ST_FULL;
						end else begin
							mem_we = 1'b1;
							count_d = count_q + CW'(1);
							status_d = ST_DONE;
						end
					end
					OP_REMOVE: begin
						if (found_q) begin
							status_d = ST_DONE;
							if (CW'(slot_q) == last_idx) begin
								count_d = last_idx;
							end else begin
								idx_d = CW'(slot_q) + CW'(1);
								state_d = S_SHIFT;
							end
						end else begin
							status_d = ST_NOT_FOUND;
						end
					end
					default: begin
						status_d = found_q ? ST_DONE : ST_NOT_FOUND;
					end
				endcase
			end
			S_SHIFT: begin
				if (cmp_v_q) begin
					mem_we = 1'b1;
					mem_waddr = AW'(cmp_idx_q - CW'(1));
					mem_wdata = mem_rdata;
				end
				if (at_last) begin
					count_d = last_idx;
					state_d = S_RESULT;
				end else if (idx_q < count_q) begin
					mem_re = 1'b1;
					idx_d = idx_q + CW'(1);
					cmp_idx_d = idx_q;
					cmp_v_d = 1'b1;
				end
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.found = found_q;
	assign res.status = status_q;
	assign res.count = CountOutW'(count_q);

endmodule

// ===== sv/bis_checker.sv =====
// Port-level checker for the bounded integer set core, bound to the top level.
// Depends on bis_pkg for the status codes.
module bis_checker #(
	parameter int CAPACITY = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic found,
	input logic [1:0] status,
	input logic [5:0] count
);
	import bis_pkg::*;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({found, status, count}))
		else $error("stalled result beat changed");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_DUPLICATE) |-> found)
		else $error("duplicate reported without a match");

	a_miss_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_FULL) || (status == ST_NOT_FOUND)) |-> !found)
		else $error("found set on a full or missing result");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (count == 6'(CAPACITY)))
		else $error("full reported below capacity");

endmodule

bind bounded_integer_set_core bis_checker #(.CAPACITY(CAPACITY)) u_bis_checker (.*);
